// ===== hdl/tpms_pkg.sv =====
package tpms_pkg;

	// Data format: temperatures and drive are signed Q16.16 held in 32 bits
	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int COEF_W    = 18;
	localparam int COEF_FRAC = 16;

	// Shared multiplier: 33 x 33 signed, registered 66-bit product
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	// Accumulator holds a*y - b*sq + c*u + d*sin without wrap (|sum| < 2^49)
	localparam int ACC_W = 50;

	// Square term: floor(y_prev^2 / 2^FRAC_BITS), capped at 2^47
	localparam int SQ_W = 48;
	localparam logic [SQ_W-1:0] SQ_CAP = SQ_W'(1) << 47;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_A     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_C     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_D     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONLINEAR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_TEMP  = 3'd5;

	// Request types
	localparam logic REQ_STEP   = 1'b0;
	localparam logic REQ_RELOAD = 1'b1;

	// Register reset values
	localparam logic signed [COEF_W-1:0] COEF_A_RST = 18'sd52429;  // 0.8
	localparam logic signed [COEF_W-1:0] COEF_B_RST = 18'sd13107;  // 0.2
	localparam logic signed [COEF_W-1:0] COEF_C_RST = 18'sd9830;   // 0.15
	localparam logic signed [COEF_W-1:0] COEF_D_RST = 18'sd6554;   // 0.1
	localparam logic signed [DATA_W-1:0] TEMP_RST   = 32'sd1638400; // 25.0

	// Sine range reduction constants
	localparam logic signed [MUL_W-1:0] INV_TWO_PI_Q32 = 33'sd683565276;
	localparam logic signed [MUL_W-1:0] HALF_PI_Q30    = 33'sd1686629713;
	localparam logic signed [MUL_W-1:0] QUARTER_TURN   = 33'sd1073741824;
	localparam logic signed [MUL_W-1:0] HALF_TURN      = 33'sd2147483648;

	// CORDIC
	localparam int CORDIC_ITER = 24;
	localparam int ITER_W      = 5;
	localparam int CORDIC_W    = 34;
	localparam int SIN_SHIFT   = 30 - FRAC_BITS;
	localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

	// atan(2^-i) in Q30 radians
	function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
		logic signed [CORDIC_W-1:0] r;
		unique case (i)
			5'd0:    r = 34'sd843314857;
			5'd1:    r = 34'sd497837829;
			5'd2:    r = 34'sd263043837;
			5'd3:    r = 34'sd133525159;
			5'd4:    r = 34'sd67021687;
			5'd5:    r = 34'sd33543516;
			5'd6:    r = 34'sd16775851;
			5'd7:    r = 34'sd8388437;
			5'd8:    r = 34'sd4194283;
			5'd9:    r = 34'sd2097149;
			5'd10:   r = 34'sd1048576;
			5'd11:   r = 34'sd524288;
			5'd12:   r = 34'sd262144;
			5'd13:   r = 34'sd131072;
			5'd14:   r = 34'sd65536;
			5'd15:   r = 34'sd32768;
			5'd16:   r = 34'sd16384;
			5'd17:   r = 34'sd8192;
			5'd18:   r = 34'sd4096;
			5'd19:   r = 34'sd2048;
			5'd20:   r = 34'sd1024;
			5'd21:   r = 34'sd512;
			5'd22:   r = 34'sd256;
			5'd23:   r = 34'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/tpms_if.sv =====
// Request channel: one plant step or a reload
interface tpms_req_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  req_type;
	logic signed [tpms_pkg::DATA_W-1:0]    drive;

	modport source (output valid, req_type, drive, input ready);
	modport sink   (input valid, req_type, drive, output ready);
endinterface

// Response channel: new temperature and clip flag
interface tpms_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [tpms_pkg::DATA_W-1:0]    temperature;
	logic                                  saturated;

	modport source (output valid, temperature, saturated, input ready);
	modport sink   (input valid, temperature, saturated, output ready);
endinterface

// ===== hdl/tpms_mul.sv =====
// Shared signed multiplier, product registered every cycle
module tpms_mul (
	input  logic                                  clk,
	input  logic signed [tpms_pkg::MUL_W-1:0]     op_a,
	input  logic signed [tpms_pkg::MUL_W-1:0]     op_b,
	output logic signed [tpms_pkg::PROD_W-1:0]    prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

// ===== hdl/tpms_cordic.sv =====
// Rotation-mode CORDIC, one micro-rotation per cycle
module tpms_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [tpms_pkg::CORDIC_W-1:0]   z0,
	output logic                                   done_q,
	output logic signed [tpms_pkg::DATA_W-1:0]     sin_val
);

	logic                                  busy_q;
	logic [tpms_pkg::ITER_W-1:0]           iter_q;
	logic signed [tpms_pkg::CORDIC_W-1:0]  x_q, y_q, z_q;
	logic signed [tpms_pkg::CORDIC_W-1:0]  x_sh, y_sh, y_res;

	assign x_sh = x_q >>> iter_q;
	assign y_sh = y_q >>> iter_q;

	// control: iteration count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (iter_q == tpms_pkg::ITER_W'(tpms_pkg::CORDIC_ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	// datapath: rotate toward z = 0
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= tpms_pkg::CORDIC_X0;
			y_q <= '0;
			z_q <= z0;
		end else if (busy_q) begin
			if (!z_q[tpms_pkg::CORDIC_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - tpms_pkg::atan_q30(iter_q);
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + tpms_pkg::atan_q30(iter_q);
			end
		end
	end

	// Q30 -> FRAC_BITS, floor
	assign y_res   = y_q >>> tpms_pkg::SIN_SHIFT;
	assign sin_val = y_res[tpms_pkg::DATA_W-1:0];

endmodule

// ===== hdl/thermal_plant_model_step_unit.sv =====
// Channel  | Dir | Beat contents
// ---------+-----+---------------------------------------------
// req      | in  | req_type (0 step, 1 reload), drive Q16.16
// rsp      | out | temperature Q16.16, saturated
// cfg_*    | in  | register index, write data (no read-back)
//
// Reload goes straight to the finish state. A nonlinear step is paced by the
// single shared multiplier (8 products, each issued in one state and taken
// in the next) and the 24-iteration CORDIC for the sine term.
// One beat is in flight at a time; req.ready is high only while idle.
// A finished beat waits in the rsp register; a stalled rsp holds the unit at
// its last cycle. arst_n clears registers and plant state to their reset values.
module thermal_plant_model_step_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [tpms_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tpms_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	tpms_req_if.sink                               req,
	tpms_rsp_if.source                             rsp
);

	typedef enum logic [18:0] {
		S_IDLE = 19'h00001,
		S_M_AY = 19'h00002,
		S_T_AY = 19'h00004,
		S_M_SQ = 19'h00008,
		S_T_SQ = 19'h00010,
		S_M_BH = 19'h00020,
		S_T_BH = 19'h00040,
		S_M_BL = 19'h00080,
		S_T_BL = 19'h00100,
		S_M_CU = 19'h00200,
		S_T_CU = 19'h00400,
		S_M_TW = 19'h00800,
		S_T_TW = 19'h01000,
		S_M_ZA = 19'h02000,
		S_T_ZA = 19'h04000,
		S_CORD = 19'h08000,
		S_M_DS = 19'h10000,
		S_T_DS = 19'h20000,
		S_FIN  = 19'h40000
	} state_t;

	localparam int DW = tpms_pkg::DATA_W;
	localparam int MW = tpms_pkg::MUL_W;
	localparam int AW = tpms_pkg::ACC_W;

	localparam logic signed [AW-1:0] OUT_MAX = AW'((64'sd1 <<< (DW - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] OUT_MIN = -OUT_MAX - AW'(1);

	state_t                              state_q;

	// configuration registers
	logic signed [tpms_pkg::COEF_W-1:0]  coef_a_q, coef_b_q, coef_c_q, coef_d_q;
	logic                                nonlinear_q;
	logic signed [DW-1:0]                init_temp_q;

	// plant state
	logic signed [DW-1:0]                temp_now_q, temp_before_q, drive_before_q;

	// per-beat working registers
	logic signed [DW-1:0]                u_q;
	logic                                reload_q;
	logic signed [AW-1:0]                acc_q;
	logic [tpms_pkg::SQ_W-1:0]           sq_q;
	logic signed [MW-1:0]                s_q;

	// output register
	logic                                out_valid_q;
	logic signed [DW-1:0]                out_temp_q;
	logic                                out_sat_q;

	// shared multiplier
	logic signed [MW-1:0]                mul_a, mul_b;
	logic signed [tpms_pkg::PROD_W-1:0]  prod_q;

	// cordic
	logic                                cordic_start;
	logic                                cordic_done;
	logic signed [tpms_pkg::CORDIC_W-1:0] cordic_z0;
	logic signed [DW-1:0]                sin_val;

	// derived values
	logic signed [MW-1:0]                temp_before_ext, temp_mag;
	logic signed [AW-1:0]                prod_q16;
	logic [tpms_pkg::SQ_W-1:0]           sq_raw;
	logic signed [MW-1:0]                turn_s;
	logic signed [DW-1:0]                clip_val;
	logic                                clip_sat;
	logic                                in_fire, fin_fire;

	assign in_fire  = req.valid && req.ready;
	assign fin_fire = (state_q == S_FIN) && (!out_valid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q    <= tpms_pkg::COEF_A_RST;
			coef_b_q    <= tpms_pkg::COEF_B_RST;
			coef_c_q    <= tpms_pkg::COEF_C_RST;
			coef_d_q    <= tpms_pkg::COEF_D_RST;
			nonlinear_q <= 1'b0;
			init_temp_q <= tpms_pkg::TEMP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tpms_pkg::REG_COEF_A:    coef_a_q    <= cfg_wdata[tpms_pkg::COEF_W-1:0];
				tpms_pkg::REG_COEF_B:    coef_b_q    <= cfg_wdata[tpms_pkg::COEF_W-1:0];
				tpms_pkg::REG_COEF_C:    coef_c_q    <= cfg_wdata[tpms_pkg::COEF_W-1:0];
				tpms_pkg::REG_COEF_D:    coef_d_q    <= cfg_wdata[tpms_pkg::COEF_W-1:0];
				tpms_pkg::REG_NONLINEAR: nonlinear_q <= cfg_wdata[0];
				tpms_pkg::REG_INIT_TEMP: init_temp_q <= cfg_wdata[DW-1:0];
				default: ;
			endcase
		end
	end

	// |y_prev| fits 32 unsigned bits, kept in the 33-bit operand
	assign temp_before_ext = MW'(temp_before_q);
	assign temp_mag = temp_before_q[DW-1] ? -temp_before_ext : temp_before_ext;

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_M_AY: begin
				mul_a = MW'(coef_a_q);
				mul_b = MW'(temp_now_q);
			end
			S_M_SQ: begin
				mul_a = temp_mag;
				mul_b = temp_mag;
			end
			S_M_BH: begin
				mul_a = MW'(coef_b_q);
				mul_b = {1'b0, sq_q[tpms_pkg::SQ_W-1:tpms_pkg::COEF_FRAC]};
			end
			S_M_BL: begin
				mul_a = MW'(coef_b_q);
				mul_b = {{(MW - tpms_pkg::COEF_FRAC){1'b0}}, sq_q[tpms_pkg::COEF_FRAC-1:0]};
			end
			S_M_CU: begin
				mul_a = nonlinear_q ? MW'(coef_c_q) : MW'(coef_b_q);
				mul_b = MW'(u_q);
			end
			S_M_TW: begin
				mul_a = MW'(drive_before_q);
				mul_b = tpms_pkg::INV_TWO_PI_Q32;
			end
			S_M_ZA: begin
				mul_a = s_q;
				mul_b = tpms_pkg::HALF_PI_Q30;
			end
			S_M_DS: begin
				mul_a = MW'(coef_d_q);
				mul_b = MW'(sin_val);
			end
			default: ;
		endcase
	end

	tpms_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	// floor(coef * x / 2^16)
	assign prod_q16 = signed'(prod_q[tpms_pkg::COEF_FRAC +: AW]);

	// square >> FRAC_BITS; the product is nonnegative
	assign sq_raw = prod_q[tpms_pkg::FRAC_BITS +: tpms_pkg::SQ_W];

	// turn fraction, signed 32 bits, extended for the fold
	assign turn_s = MW'(signed'(prod_q[tpms_pkg::FRAC_BITS +: DW]));

	// angle in Q30 radians
	assign cordic_z0    = prod_q[30 +: tpms_pkg::CORDIC_W];
	assign cordic_start = (state_q == S_T_ZA);

	tpms_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.z0      (cordic_z0),
		.done_q  (cordic_done),
		.sin_val (sin_val)
	);

	// clip the sum to the output range
	always_comb begin
		clip_sat = 1'b0;
		clip_val = acc_q[DW-1:0];
		if (acc_q > OUT_MAX) begin
			clip_sat = 1'b1;
			clip_val = OUT_MAX[DW-1:0];
		end else if (acc_q < OUT_MIN) begin
			clip_sat = 1'b1;
			clip_val = OUT_MIN[DW-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					state_q <= (req.req_type == tpms_pkg::REQ_RELOAD) ? S_FIN : S_M_AY;
				end
				S_M_AY: state_q <= S_T_AY;
				S_T_AY: state_q <= nonlinear_q ? S_M_SQ : S_M_CU;
				S_M_SQ: state_q <= S_T_SQ;
				S_T_SQ: state_q <= S_M_BH;
				S_M_BH: state_q <= S_T_BH;
				S_T_BH: state_q <= S_M_BL;
				S_M_BL: state_q <= S_T_BL;
				S_T_BL: state_q <= S_M_CU;
				S_M_CU: state_q <= S_T_CU;
				S_T_CU: state_q <= nonlinear_q ? S_M_TW : S_FIN;
				S_M_TW: state_q <= S_T_TW;
				S_T_TW: state_q <= S_M_ZA;
				S_M_ZA: state_q <= S_T_ZA;
				S_T_ZA: state_q <= S_CORD;
				S_CORD: if (cordic_done) begin
					state_q <= S_M_DS;
				end
				S_M_DS: state_q <= S_T_DS;
				S_T_DS: state_q <= S_FIN;
				S_FIN:  if (fin_fire) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers: accumulate terms as products arrive
	always_ff @(posedge clk) begin
		if (in_fire) begin
			u_q      <= req.drive;
			reload_q <= (req.req_type == tpms_pkg::REQ_RELOAD);
			acc_q    <= AW'(init_temp_q);
		end
		unique case (state_q)
			S_T_AY: acc_q <= prod_q16;
			S_T_SQ: sq_q  <= (sq_raw > tpms_pkg::SQ_CAP) ? tpms_pkg::SQ_CAP : sq_raw;
			S_T_BH: acc_q <= acc_q - prod_q[AW-1:0];
			S_T_BL: acc_q <= acc_q - prod_q16;
			S_T_CU: acc_q <= acc_q + prod_q16;
			S_T_DS: acc_q <= acc_q + prod_q16;
			S_T_TW: begin
				// fold the turn fraction into [-1/4, 1/4] turn
				if (turn_s > tpms_pkg::QUARTER_TURN) begin
					s_q <= tpms_pkg::HALF_TURN - turn_s;
				end else if (turn_s < -tpms_pkg::QUARTER_TURN) begin
					s_q <= -tpms_pkg::HALF_TURN - turn_s;
				end else begin
					s_q <= turn_s;
				end
			end
			default: ;
		endcase
	end

	// plant state update on completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_now_q     <= tpms_pkg::TEMP_RST;
			temp_before_q  <= tpms_pkg::TEMP_RST;
			drive_before_q <= '0;
		end else if (fin_fire) begin
			temp_now_q <= clip_val;
			if (reload_q) begin
				temp_before_q  <= clip_val;
				drive_before_q <= '0;
			end else begin
				temp_before_q  <= temp_now_q;
				drive_before_q <= u_q;
			end
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			out_temp_q <= clip_val;
			out_sat_q  <= clip_sat;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.temperature = out_temp_q;
	assign rsp.saturated   = out_sat_q;

endmodule

// ===== tb/sv/thermal_plant_model_step_unit_tb.sv =====
module thermal_plant_model_step_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tpms_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 5;
	localparam int SETTLE_CYCLES   = 8;
	localparam int DRAIN_CYCLES    = 60;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int PHASES          = 8;
	localparam int PHASE_ITEMS     = 88;
	localparam int HOLD_CYCLES     = 400;
	localparam int DIR_ROWS        = 34;

	// indexes past the last register; writes to them must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	localparam longint TEMP_MAX   = 64'sd2147483647;
	localparam longint TEMP_MIN   = -64'sd2147483648;
	localparam longint SQ_LIMIT   = 64'sd140737488355328;
	localparam longint TURN_QTR   = 64'sd1073741824;
	localparam longint TURN_HALF  = 64'sd2147483648;
	localparam longint RAD_HALFPI = 64'sd1686629713;
	localparam longint ROT_GAIN   = 64'sd652032874;

	typedef struct packed {
		logic signed [DATA_W-1:0] temperature;
		logic                     saturated;
	} temp_beat_t;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_CHECKED,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic                     rtype;
		logic [CFG_IDX_W-1:0]     idx;
		logic [31:0]              value;
		logic [DATA_W-1:0]        k_temp;
		logic                     k_sat;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tpms_req_if req_bus ();
	tpms_rsp_if rsp_bus ();

	thermal_plant_model_step_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	always #CLK_HALF clk = ~clk;

	// predictor copy of registers and plant state
	logic signed [COEF_W-1:0] gain_a, gain_b, gain_c, gain_d;
	logic                     nonlinear_mode;
	logic signed [DATA_W-1:0] reload_temp;
	longint                   plant_y, plant_y_prev, plant_u_prev;

	temp_beat_t expected_temps [$];
	int         fail_count = 0;

	bit req_idle_on, rsp_idle_on;
	int rsp_hold_req = 0;
	int rsp_stall_left = 0;
	int idle_cycles = 0;

	longint atan_tbl [0:23] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};

	dir_row_t dir_rows [0:DIR_ROWS-1];

	// floor(c * x / 2^16), exact
	function automatic longint scale_coef(input logic signed [COEF_W-1:0] c, input longint x);
		logic signed [95:0] cw, xw, prod;
		cw = c;
		xw = x;
		prod = cw * xw;
		return longint'(prod >>> COEF_FRAC);
	endfunction

	function automatic longint square_scaled(input longint v);
		longint unsigned mag, p;
		mag = (v < 0) ? -v : v;
		if (mag >= 64'd4294967296)
			return SQ_LIMIT;
		p = (mag * mag) >> FRAC_BITS;
		return (p > SQ_LIMIT) ? SQ_LIMIT : longint'(p);
	endfunction

	// turn fraction, fold to +-quarter turn, rotate by CORDIC
	function automatic longint sine_fixed(input longint u);
		logic signed [79:0] uw, prod;
		logic signed [31:0] turn;
		longint s, x, y, z, nx;
		uw = u;
		prod = uw * 80'sd683565276;
		turn = prod[47:16];
		s = turn;
		if (s > TURN_QTR)
			s = TURN_HALF - s;
		else if (s < -TURN_QTR)
			s = -TURN_HALF - s;
		z = (s * RAD_HALFPI) >>> 30;
		x = ROT_GAIN;
		y = 0;
		for (int i = 0; i < CORDIC_ITER; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - atan_tbl[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + atan_tbl[i];
			end
			x = nx;
		end
		return y >>> (30 - FRAC_BITS);
	endfunction

	function automatic longint clamp_temp(input longint v, output logic hit);
		hit = 1'b0;
		if (v > TEMP_MAX) begin
			hit = 1'b1;
			return TEMP_MAX;
		end
		if (v < TEMP_MIN) begin
			hit = 1'b1;
			return TEMP_MIN;
		end
		return v;
	endfunction

	// advance the plant copy by one request, return the temperature beat it yields
	function automatic temp_beat_t plant_next(input logic rtype, input logic signed [DATA_W-1:0] u);
		temp_beat_t r;
		longint     uu, sum;
		logic       hit;
		uu = u;
		if (rtype == REQ_RELOAD) begin
			sum = reload_temp;
			plant_y = clamp_temp(sum, hit);
			plant_y_prev = plant_y;
			plant_u_prev = 0;
		end else begin
			if (!nonlinear_mode)
				sum = scale_coef(gain_a, plant_y) + scale_coef(gain_b, uu);
			else
				sum = scale_coef(gain_a, plant_y)
				    - scale_coef(gain_b, square_scaled(plant_y_prev))
				    + scale_coef(gain_c, uu)
				    + scale_coef(gain_d, sine_fixed(plant_u_prev));
			plant_y_prev = plant_y;
			plant_u_prev = uu;
			plant_y = clamp_temp(sum, hit);
		end
		r.temperature = plant_y[DATA_W-1:0];
		r.saturated = hit;
		return r;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		case (idx)
			REG_COEF_A:    gain_a = data[COEF_W-1:0];
			REG_COEF_B:    gain_b = data[COEF_W-1:0];
			REG_COEF_C:    gain_c = data[COEF_W-1:0];
			REG_COEF_D:    gain_d = data[COEF_W-1:0];
			REG_NONLINEAR: nonlinear_mode = data[0];
			REG_INIT_TEMP: reload_temp = data[DATA_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic dir_row_t step_row(input logic rt, input logic [31:0] d);
		return '{ROW_ITEM, rt, 3'd0, d, 32'd0, 1'b0};
	endfunction

	function automatic dir_row_t known_row(input logic rt, input logic [31:0] d,
			input logic [31:0] t, input logic s);
		return '{ROW_CHECKED, rt, 3'd0, d, t, s};
	endfunction

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		return '{ROW_CFG, REQ_STEP, idx, d, 32'd0, 1'b0};
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (!req_idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_drive();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return 32'(int'($urandom_range(0, 100 << 16)) - (50 << 16));
			7:          return 32'(int'($urandom_range(0, 16 << 16)) - (8 << 16));
			8: begin
				case ($urandom_range(0, 3))
					0:       return 32'h7FFF_FFFF;
					1:       return 32'h8000_0000;
					2:       return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default:    return 32'(int'($urandom_range(0, 512)) - 256);
		endcase
	endfunction

	function automatic logic [31:0] pick_coef();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0:       return 32'h0001_FFFF;
			1:       return 32'h0002_0000;
			2:       return $urandom;
			default: return 32'(int'($urandom_range(0, 98304)) - 32768);
		endcase
	endfunction

	function automatic logic [31:0] pick_init_temp();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return $urandom;
			default: return 32'(int'($urandom_range(0, 200 << 16)) - (100 << 16));
		endcase
	endfunction

	// offer one request beat, predict its result once accepted
	task automatic send_item(input logic rt, input logic [31:0] d, input logic typed,
			input temp_beat_t typed_val);
		int         gap;
		temp_beat_t want;
		gap = pick_gap();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid    <= 1'b1;
		req_bus.req_type <= rt;
		req_bus.drive    <= d;
		do @(posedge clk); while (!req_bus.ready);
		want = plant_next(rt, d);
		if (typed)
			want = typed_val;
		expected_temps = {expected_temps, want};
	endtask

	// stop offering and let every pending result drain
	task automatic wait_idle();
		req_bus.valid <= 1'b0;
		wait (expected_temps.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		apply_reg(idx, data);
	endtask

	// response side: random stalls plus requested long hold-offs
	always @(posedge clk) begin
		if (rsp_hold_req > 0) begin
			rsp_stall_left = rsp_hold_req;
			rsp_hold_req = 0;
		end
		if (rsp_stall_left > 0) begin
			rsp_stall_left--;
			rsp_bus.ready <= 1'b0;
		end else if (rsp_idle_on && $urandom_range(0, 99) < 20) begin
			rsp_stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
			                                                : $urandom_range(0, 3);
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= 1'b1;
		end
	end

	// compare each accepted result beat with the oldest expectation
	always @(posedge clk) begin
		temp_beat_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (expected_temps.size() == 0) begin
				$error("unexpected result beat: temperature %0d saturated %0b",
					rsp_bus.temperature, rsp_bus.saturated);
				fail_count++;
			end else begin
				want = expected_temps.pop_front();
				if (rsp_bus.temperature !== want.temperature) begin
					$error("temperature: expected %0d, got %0d",
						want.temperature, rsp_bus.temperature);
					fail_count++;
				end
				if (rsp_bus.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b",
						want.saturated, rsp_bus.saturated);
					fail_count++;
				end
			end
		end
	end

	// watchdog: too long with no beat on either side
	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic rt;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_wdata        = '0;
		req_bus.valid    = 1'b0;
		req_bus.req_type = REQ_STEP;
		req_bus.drive    = '0;
		req_idle_on      = 1'b1;
		rsp_idle_on      = 1'b1;

		// plant copy after reset
		gain_a         = COEF_A_RST;
		gain_b         = COEF_B_RST;
		gain_c         = COEF_C_RST;
		gain_d         = COEF_D_RST;
		nonlinear_mode = 1'b0;
		reload_temp    = TEMP_RST;
		plant_y        = TEMP_RST;
		plant_y_prev   = TEMP_RST;
		plant_u_prev   = 0;

		dir_rows = '{
			known_row(REQ_RELOAD, 32'h0000_0000, TEMP_RST, 1'b0),
			step_row(REQ_STEP, 32'h0000_0000),
			step_row(REQ_STEP, 32'h7FFF_FFFF),
			step_row(REQ_STEP, 32'h8000_0000),
			step_row(REQ_STEP, 32'hFFFF_FFFF),
			// reload ignores the drive value
			known_row(REQ_RELOAD, 32'hDEAD_BEEF, TEMP_RST, 1'b0),
			// only bit 0 of the mode register counts
			cfg_row(REG_NONLINEAR, 32'hFFFF_FFFF),
			step_row(REQ_STEP, 32'h0003_243F),
			step_row(REQ_STEP, 32'hFFFC_DBC1),
			step_row(REQ_STEP, 32'h0001_9220),
			step_row(REQ_STEP, 32'h7FFF_FFFF),
			step_row(REQ_STEP, 32'h8000_0000),
			step_row(REQ_STEP, 32'h0000_0000),
			cfg_row(REG_NONLINEAR, 32'h0000_0002),
			step_row(REQ_STEP, 32'h0001_0000),
			// clip high and low from the extreme temperatures
			cfg_row(REG_COEF_A, 32'h0001_FFFF),
			cfg_row(REG_INIT_TEMP, 32'h7FFF_FFFF),
			known_row(REQ_RELOAD, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0),
			known_row(REQ_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1),
			cfg_row(REG_INIT_TEMP, 32'h8000_0000),
			known_row(REQ_RELOAD, 32'h5555_5555, 32'h8000_0000, 1'b0),
			known_row(REQ_STEP, 32'h8000_0000, 32'h8000_0000, 1'b1),
			// nonlinear with extreme gains and a huge previous temperature
			cfg_row(REG_COEF_B, 32'h0002_0000),
			cfg_row(REG_COEF_C, 32'h0002_0000),
			cfg_row(REG_COEF_D, 32'h0001_FFFF),
			cfg_row(REG_NONLINEAR, 32'h0000_0001),
			step_row(REQ_STEP, 32'h7FFF_FFFF),
			step_row(REQ_STEP, 32'h1234_5678),
			cfg_row(REG_UNMAPPED_LO, 32'hFFFF_FFFF),
			cfg_row(REG_UNMAPPED_HI, 32'h0000_0000),
			step_row(REQ_STEP, 32'h8000_0000),
			// upper write data bits of a gain are dropped
			cfg_row(REG_COEF_A, 32'hFFFE_0000),
			known_row(REQ_RELOAD, 32'hAAAA_AAAA, 32'h8000_0000, 1'b0),
			step_row(REQ_STEP, 32'h4000_0000)
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(dir_rows[i].idx, dir_rows[i].value);
				cfg_we <= 1'b0;
			end else begin
				send_item(dir_rows[i].rtype, dir_rows[i].value,
					dir_rows[i].kind == ROW_CHECKED,
					'{dir_rows[i].k_temp, dir_rows[i].k_sat});
			end
		end

		// random phases, each with its own register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			logic [31:0] mode_word;
			wait_idle();
			req_idle_on = (phase != 0);
			rsp_idle_on = (phase != 0);
			mode_word = $urandom;
			mode_word[0] = phase[0];
			write_reg(REG_COEF_A, pick_coef());
			write_reg(REG_COEF_B, pick_coef());
			write_reg(REG_COEF_C, pick_coef());
			write_reg(REG_COEF_D, pick_coef());
			write_reg(REG_NONLINEAR, mode_word);
			write_reg(REG_INIT_TEMP, pick_init_temp());
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, $urandom);
			cfg_we <= 1'b0;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// receiver holds off while requests keep coming
				if (phase == 2 && k == 10)
					rsp_hold_req = HOLD_CYCLES;
				// sender pauses until everything has come back
				if (phase == 5 && k == 44)
					wait_idle();
				rt = ($urandom_range(0, 99) < 6) ? REQ_RELOAD : REQ_STEP;
				send_item(rt, pick_drive(), 1'b0, '0);
			end
		end

		req_bus.valid <= 1'b0;
		wait (expected_temps.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== thermal_plant_model_step_unit.f =====
hdl/tpms_pkg.sv
hdl/tpms_if.sv
hdl/tpms_mul.sv
hdl/tpms_cordic.sv
hdl/thermal_plant_model_step_unit.sv
tb/sv/thermal_plant_model_step_unit_tb.sv
